/* hw/rtl/rgdd_pkg.sv */
// ----------------------------------------------------------------------------
// rgdd_pkg
// Shared types and constants for the resource-graph deadlock detector.
// ----------------------------------------------------------------------------
package rgdd_pkg;

    // Fixed field widths of the channels
    localparam int ID_W   = 5;
    localparam int MASK_W = 32;

    // Edge kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_ALLOC   = 1'b1;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [MASK_W-1:0] mask_t;

endpackage

/* hw/rtl/rgdd_in_if.sv */
// ----------------------------------------------------------------------------
// rgdd_in_if
// Edge input channel: one beat carries one graph edge.
// ----------------------------------------------------------------------------
interface rgdd_in_if
    import rgdd_pkg::*;
;
    logic valid;
    logic ready;
    id_t  process_id;
    id_t  resource_id;
    logic kind;

    modport source (output valid, output process_id, output resource_id, output kind,
                    input ready);
    modport sink   (input valid, input process_id, input resource_id, input kind,
                    output ready);
endinterface

/* hw/rtl/rgdd_out_if.sv */
// ----------------------------------------------------------------------------
// rgdd_out_if
// Result channel: one beat per edge with the deadlock verdict.
// ----------------------------------------------------------------------------
interface rgdd_out_if
    import rgdd_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  deadlock_found;
    mask_t deadlocked_mask;
    logic  edge_dropped;

    modport source (output valid, output deadlock_found, output deadlocked_mask,
                    output edge_dropped, input ready);
    modport sink   (input valid, input deadlock_found, input deadlocked_mask,
                    input edge_dropped, output ready);
endinterface

/* hw/rtl/rgdd_ram.sv */
// ----------------------------------------------------------------------------
// rgdd_ram
// Single-port-write, single-port-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rgdd_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 18
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/resource_graph_deadlock_detector.sv */
// ----------------------------------------------------------------------------
// resource_graph_deadlock_detector
// Adds each input beat's edge, unless it is dropped, to a stored resource-allocation graph, then
// peels nodes of zero out-degree until none is left to remove; processes
// that remain are reported as deadlocked.
// ----------------------------------------------------------------------------
//  Channel   Dir   Beat payload
//  in_ch     in    process_id, resource_id, kind (0 request, 1 allocation)
//  out_ch    out   deadlock_found, deadlocked_mask, edge_dropped
//
//  Steps per edge: accept, then for a stored edge an out-degree bump and
//  a clear of a first-seen target, a degree copy over all N nodes, peel
//  passes over each node with a scan of all E stored edges for each node
//  removed, and finish; N nodes, E stored edges, at most N+1 passes. Reset
//  clears the edge count, node-present bits and the control state; degree
//  entries are cleared when a node first appears. in_ch is ready only
//  while idle, also while a result waits on out_ch; a stalled out_ch
//  holds the next finished result.
// ----------------------------------------------------------------------------
module resource_graph_deadlock_detector
    import rgdd_pkg::*;
#(
    parameter int NUM_PROCS     = 32,
    parameter int NUM_RESOURCES = 32,
    parameter int MAX_EDGES     = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    rgdd_in_if.sink     in_ch,
    rgdd_out_if.source  out_ch
);

    localparam int NODES  = NUM_PROCS + NUM_RESOURCES;
    localparam int NW     = $clog2(NODES);
    localparam int AW     = $clog2(MAX_EDGES);
    localparam int CW     = $clog2(MAX_EDGES + 1);
    localparam int DW     = CW;
    localparam int EDGE_W = 2 * NW;
    localparam int DEG_W  = 2 * DW;

    localparam logic [ID_W:0] PROC_LIM = (ID_W + 1)'(NUM_PROCS);
    localparam logic [ID_W:0] RES_LIM  = (ID_W + 1)'(NUM_RESOURCES);
    localparam logic [CW-1:0] EDGE_LIM = CW'(MAX_EDGES);
    localparam logic [NW-1:0] LAST_N   = NW'(NODES - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ADD_WR  = 4'd1;
    localparam logic [3:0] ST_CP_RD   = 4'd2;
    localparam logic [3:0] ST_CP_WR   = 4'd3;
    localparam logic [3:0] ST_PL_RD   = 4'd4;
    localparam logic [3:0] ST_PL_CHK  = 4'd5;
    localparam logic [3:0] ST_E_RD    = 4'd6;
    localparam logic [3:0] ST_E_CHK   = 4'd7;
    localparam logic [3:0] ST_DEC_WR  = 4'd8;
    localparam logic [3:0] ST_FINISH  = 4'd9;
    localparam logic [3:0] ST_ADD_DST = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [NODES-1:0] present_reg, present_next;
    logic [NODES-1:0] gone_reg, gone_next;
    logic [NW-1:0]    node_reg, node_next;
    logic [AW-1:0]    edge_reg, edge_next;
    logic [NW-1:0]    src_reg, src_next;
    logic             src_was_reg, src_was_next;
    logic [NW-1:0]    dst_reg, dst_next;
    logic             dst_was_reg, dst_was_next;
    logic             progress_reg, progress_next;
    logic             drop_reg, drop_next;
    logic             ovalid_reg, ovalid_next;
    logic             found_reg, found_next;
    mask_t            mask_reg, mask_next;
    logic             dropped_reg, dropped_next;

    // Memory ports
    logic              e_we;
    logic [AW-1:0]     e_waddr, e_raddr;
    logic [EDGE_W-1:0] e_wdata, e_rdata;
    logic              d_we;
    logic [NW-1:0]     d_waddr, d_raddr;
    logic [DEG_W-1:0]  d_wdata, d_rdata;

    rgdd_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDGE_W)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // Entry = {stored out-degree, working out-degree}
    rgdd_ram #(.DEPTH(NODES), .WIDTH(DEG_W)) u_deg_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    logic [DW-1:0] rd_out, rd_work;
    logic [NW-1:0] ed_src, ed_dst;
    logic          accept;
    logic          drop_in;
    logic [NW-1:0] pn, rn, s_in, d_in;
    logic          last_edge;

    assign rd_out  = d_rdata[DEG_W-1:DW];
    assign rd_work = d_rdata[DW-1:0];
    assign ed_src  = e_rdata[EDGE_W-1:NW];
    assign ed_dst  = e_rdata[NW-1:0];

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // Edge decode
    assign drop_in = ({1'b0, in_ch.process_id} >= PROC_LIM)
                  || ({1'b0, in_ch.resource_id} >= RES_LIM)
                  || (count_reg >= EDGE_LIM);
    assign pn      = NW'(in_ch.process_id);
    assign rn      = NW'(NUM_PROCS) + NW'(in_ch.resource_id);
    assign s_in    = (in_ch.kind == KIND_ALLOC) ? rn : pn;
    assign d_in    = (in_ch.kind == KIND_ALLOC) ? pn : rn;
    assign last_edge = ((CW'(edge_reg) + CW'(1)) == count_reg);

    assign out_ch.valid           = ovalid_reg;
    assign out_ch.deadlock_found  = found_reg;
    assign out_ch.deadlocked_mask = mask_reg;
    assign out_ch.edge_dropped    = dropped_reg;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        present_next  = present_reg;
        gone_next     = gone_reg;
        node_next     = node_reg;
        edge_next     = edge_reg;
        src_next      = src_reg;
        src_was_next  = src_was_reg;
        dst_next      = dst_reg;
        dst_was_next  = dst_was_reg;
        progress_next = progress_reg;
        drop_next     = drop_reg;
        ovalid_next   = ovalid_reg;
        found_next    = found_reg;
        mask_next     = mask_reg;
        dropped_next  = dropped_reg;

        e_we    = 1'b0;
        e_waddr = count_reg[AW-1:0];
        e_wdata = {s_in, d_in};
        e_raddr = edge_reg;
        d_we    = 1'b0;
        d_waddr = node_reg;
        d_wdata = d_rdata;
        d_raddr = node_reg;

        if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    drop_next = drop_in;
                    node_next = '0;
                    if (drop_in)
                    begin
                        state_next = ST_CP_RD;
                    end
                    else
                    begin
                        e_we         = 1'b1;
                        count_next   = count_reg + CW'(1);
                        src_next     = s_in;
                        src_was_next = present_reg[s_in];
                        dst_next     = d_in;
                        dst_was_next = present_reg[d_in];
                        present_next[s_in] = 1'b1;
                        present_next[d_in] = 1'b1;
                        d_raddr      = s_in;
                        state_next   = ST_ADD_WR;
                    end
                end
            end
            ST_ADD_WR:
            begin
                // Bump stored out-degree; unseen nodes read as zero
                d_we    = 1'b1;
                d_waddr = src_reg;
                d_wdata = {(src_was_reg ? rd_out : DW'(0)) + DW'(1), rd_work};
                state_next = dst_was_reg ? ST_CP_RD : ST_ADD_DST;
            end
            ST_ADD_DST:
            begin
                // First-seen target starts with no out-edges
                d_we       = 1'b1;
                d_waddr    = dst_reg;
                d_wdata    = '0;
                state_next = ST_CP_RD;
            end
            ST_CP_RD:
            begin
                state_next = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                // Working degree starts at the stored degree
                d_we    = 1'b1;
                d_wdata = present_reg[node_reg] ? {rd_out, rd_out} : '0;
                if (node_reg == LAST_N)
                begin
                    node_next     = '0;
                    gone_next     = '0;
                    progress_next = 1'b0;
                    state_next    = ST_PL_RD;
                end
                else
                begin
                    node_next  = node_reg + NW'(1);
                    state_next = ST_CP_RD;
                end
            end
            ST_PL_RD:
            begin
                if (present_reg[node_reg] && !gone_reg[node_reg])
                begin
                    state_next = ST_PL_CHK;
                end
                else if (node_reg != LAST_N)
                begin
                    node_next = node_reg + NW'(1);
                end
                else if (progress_reg)
                begin
                    node_next     = '0;
                    progress_next = 1'b0;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PL_CHK:
            begin
                if (rd_work == '0)
                begin
                    gone_next[node_reg] = 1'b1;
                    progress_next = 1'b1;
                    edge_next     = '0;
                end
                if (rd_work == '0 && count_reg != '0)
                begin
                    state_next = ST_E_RD;
                end
                else
                begin
                    state_next = ST_PL_RD;
                    if (node_reg != LAST_N)
                    begin
                        node_next = node_reg + NW'(1);
                    end
                    else if (progress_next)
                    begin
                        node_next     = '0;
                        progress_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_E_RD:
            begin
                state_next = ST_E_CHK;
            end
            ST_E_CHK, ST_DEC_WR:
            begin
                if (state_reg == ST_E_CHK && ed_dst == node_reg)
                begin
                    src_next   = ed_src;
                    d_raddr    = ed_src;
                    state_next = ST_DEC_WR;
                end
                else
                begin
                    if (state_reg == ST_DEC_WR)
                    begin
                        // Removed node releases one out-edge of its source
                        d_we    = 1'b1;
                        d_waddr = src_reg;
                        d_wdata = {rd_out, (rd_work != '0) ? rd_work - DW'(1) : rd_work};
                    end
                    if (!last_edge)
                    begin
                        edge_next  = edge_reg + AW'(1);
                        state_next = ST_E_RD;
                    end
                    else
                    begin
                        state_next = ST_PL_RD;
                        if (node_reg != LAST_N)
                        begin
                            node_next = node_reg + NW'(1);
                        end
                        else
                        begin
                            node_next     = '0;
                            progress_next = 1'b0;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next  = 1'b1;
                    mask_next    = MASK_W'(present_reg[NUM_PROCS-1:0]
                                           & ~gone_reg[NUM_PROCS-1:0]);
                    found_next   = ((present_reg[NUM_PROCS-1:0]
                                     & ~gone_reg[NUM_PROCS-1:0]) != '0);
                    dropped_next = drop_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            present_reg  <= '0;
            gone_reg     <= '0;
            progress_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            present_reg  <= present_next;
            gone_reg     <= gone_next;
            progress_reg <= progress_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Payload and index registers
    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        edge_reg    <= edge_next;
        src_reg     <= src_next;
        src_was_reg <= src_was_next;
        dst_reg     <= dst_next;
        dst_was_reg <= dst_was_next;
        drop_reg    <= drop_next;
        found_reg   <= found_next;
        mask_reg    <= mask_next;
        dropped_reg <= dropped_next;
    end

endmodule
